/* sv/md5ps_pkg.sv */
// ============================================================================
// md5ps_pkg
// Shared types, constants and MD5 round tables for the password search core.
// ============================================================================
package md5ps_pkg;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TRY  = 1'b1;

    // candidate expansion
    localparam int          RADIX        = 26;
    localparam logic [7:0]  CHAR_A       = 8'h61;
    localparam logic [31:0] RECIP_RADIX  = 32'd2643056797; // floor(2^36 / 26)
    localparam int          RECIP_SHIFT  = 36;

    // stream widths
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 64;
    localparam int CAND_W     = 29;
    localparam int TEXT_W     = 48;
    localparam int MAX_LEN    = 8;

    // MD5 initial chaining values
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    // queue between front and back
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic                   cmd;
        logic [3:0]             slot;
        logic [63:0]            dig_hi;
        logic [63:0]            dig_lo;
        logic [MAX_LEN*8-1:0]   letters;   // byte i = letter i of the message
    } queue_entry_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_HASH,
        B_FIN,
        B_CMP
    } back_state_t;

    // per-round additive constants
    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // rotate amounts, indexed by {round group, round[1:0]}
    function automatic logic [4:0] md5_rot(input logic [3:0] i);
        logic [4:0] s;
        unique case (i)
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage

/* sv/md5_password_search_core.sv */
// ============================================================================
// md5_password_search_core
// Brute-force MD5 password search against a table of target digests.
// ============================================================================
//
//  channel   dir  beat contents
//  s_axis    in   tuser: command; tdata: slot, digest_high, digest_low, candidate
//  m_axis    out  tuser: matched, skipped; tdata: match_slot, password_text, remaining
//
//  Load: queued on its accepting edge, then popped into the result register.
//  Try: expanded into base-26 letters, queued, then popped by the back end,
//  hashed in 64 MD5 rounds on one round unit, finalized and compared before
//  the result register is written. The round unit sets the pace: the back
//  end takes no new try until the last one is compared. Reset clears the
//  valid marks and the queue; a stalled result register holds the back end
//  while the queue, until full, lets the front keep taking beats.
//
module md5_password_search_core
    import md5ps_pkg::*;
#(
    parameter int PASSWORD_LENGTH = 6,
    parameter int TARGET_SLOTS    = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [3:0] slot, [67:4] digest_high, [131:68] digest_low, [160:132] candidate
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // [0] command
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [3:0] match_slot, [51:4] password_text, [56:52] remaining
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    // [0] matched, [1] skipped
    output logic [1:0]             m_axis_tuser
);

    logic          push, pop, q_full, q_empty;
    queue_entry_t  push_data, pop_data;
    logic          o_matched, o_skipped;
    logic [3:0]    o_slot;
    logic [TEXT_W-1:0] o_text;
    logic [4:0]    o_rem;

    md5ps_front #(
        .PASSWORD_LENGTH (PASSWORD_LENGTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (s_axis_tuser),
        .in_slot   (s_axis_tdata[3:0]),
        .in_dig_hi (s_axis_tdata[67:4]),
        .in_dig_lo (s_axis_tdata[131:68]),
        .in_cand   (s_axis_tdata[160:132]),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    md5ps_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    md5ps_back #(
        .PASSWORD_LENGTH (PASSWORD_LENGTH),
        .TARGET_SLOTS    (TARGET_SLOTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (pop_data),
        .pop           (pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_matched   (o_matched),
        .out_slot      (o_slot),
        .out_text      (o_text),
        .out_remaining (o_rem),
        .out_skipped   (o_skipped)
    );

    // result beat packing
    assign m_axis_tdata = {7'd0, o_rem, o_text, o_slot};
    assign m_axis_tuser = {o_skipped, o_matched};

endmodule

/* sv/md5ps_front.sv */
// ============================================================================
// md5ps_front
// Accepts input beats; loads go straight to the queue, tries are expanded
// into base-26 letters one digit per cycle before being queued.
// ============================================================================
module md5ps_front
    import md5ps_pkg::*;
#(
    parameter int PASSWORD_LENGTH = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_cmd,
    input  logic [3:0]           in_slot,
    input  logic [63:0]          in_dig_hi,
    input  logic [63:0]          in_dig_lo,
    input  logic [CAND_W-1:0]    in_cand,
    output logic                 push,
    output queue_entry_t         push_data,
    input  logic                 q_full
);

    localparam int IW = (PASSWORD_LENGTH > 1) ? $clog2(PASSWORD_LENGTH) : 1;

    front_state_t         state_reg, state_next;
    logic [CAND_W-1:0]    rem_reg, rem_next;
    logic [IW-1:0]        idx_reg, idx_next;
    queue_entry_t         ent_reg, ent_next;

    // digit extraction: reciprocal multiply, one correction step
    logic [60:0]          prod;
    logic [24:0]          q0;
    logic [CAND_W:0]      r0;
    logic [CAND_W-1:0]    quot;
    logic [7:0]           digit;

    always_comb
    begin
        prod = 61'(rem_reg) * 61'(RECIP_RADIX);
        q0   = 25'(prod >> RECIP_SHIFT);
        r0   = (CAND_W+1)'(rem_reg) - (CAND_W+1)'(q0) * (CAND_W+1)'(RADIX);
        if (r0 >= (CAND_W+1)'(RADIX))
        begin
            quot  = CAND_W'(q0) + CAND_W'(1);
            digit = 8'(r0 - (CAND_W+1)'(RADIX));
        end
        else
        begin
            quot  = CAND_W'(q0);
            digit = 8'(r0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        idx_reg <= idx_next;
        ent_reg <= ent_next;
    end

    // next state and handshake
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        ent_next   = ent_reg;
        in_ready   = 1'b0;
        push       = 1'b0;
        push_data  = ent_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                in_ready          = !q_full;
                push_data.cmd     = CMD_LOAD;
                push_data.slot    = in_slot;
                push_data.dig_hi  = in_dig_hi;
                push_data.dig_lo  = in_dig_lo;
                push_data.letters = '0;
                if (in_valid && !q_full)
                begin
                    if (in_cmd == CMD_LOAD)
                    begin
                        push = 1'b1;
                    end
                    else
                    begin
                        ent_next         = push_data;
                        ent_next.cmd     = CMD_TRY;
                        rem_next         = in_cand;
                        idx_next         = IW'(PASSWORD_LENGTH - 1);
                        state_next       = F_CONV;
                    end
                end
            end
            F_CONV:
            begin
                ent_next.letters[idx_reg*8 +: 8] = CHAR_A + digit;
                rem_next = quot;
                idx_next = idx_reg - IW'(1);
                if (idx_reg == '0)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

/* sv/md5ps_fifo.sv */
// ============================================================================
// md5ps_fifo
// Short queue of decoded commands between the front and the hash back end.
// ============================================================================
module md5ps_fifo
    import md5ps_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  queue_entry_t  push_data,
    output logic          full,
    input  logic          pop,
    output queue_entry_t  pop_data,
    output logic          empty
);

    localparam int PW = $clog2(QDEPTH);

    queue_entry_t         mem [QDEPTH];
    logic [PW-1:0]        wr_reg, wr_next;
    logic [PW-1:0]        rd_reg, rd_next;
    logic [PW:0]          cnt_reg, cnt_next;

    assign full     = (cnt_reg == (PW+1)'(QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + PW'(1) : wr_reg;
        rd_next  = pop  ? rd_reg + PW'(1) : rd_reg;
        cnt_next = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_data;
        end
    end

endmodule

/* sv/md5ps_back.sv */
// ============================================================================
// md5ps_back
// Target table, iterative MD5 round unit, match search and result register.
// ============================================================================
module md5ps_back
    import md5ps_pkg::*;
#(
    parameter int PASSWORD_LENGTH = 6,
    parameter int TARGET_SLOTS    = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  queue_entry_t        q_data,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_matched,
    output logic [3:0]          out_slot,
    output logic [TEXT_W-1:0]   out_text,
    output logic [4:0]          out_remaining,
    output logic                out_skipped
);

    localparam int SW = (TARGET_SLOTS > 1) ? $clog2(TARGET_SLOTS) : 1;
    localparam int CW = $clog2(TARGET_SLOTS + 1);

    back_state_t              state_reg, state_next;
    logic [63:0]              tgt_hi [TARGET_SLOTS];
    logic [63:0]              tgt_lo [TARGET_SLOTS];
    logic [TARGET_SLOTS-1:0]  valid_reg, valid_next;
    logic [CW-1:0]            count_reg, count_next;

    logic [MAX_LEN*8-1:0]     let_reg, let_next;
    logic [31:0]              a_reg, b_reg, c_reg, d_reg;
    logic [31:0]              a_next, b_next, c_next, d_next;
    logic [5:0]               round_reg, round_next;
    logic [63:0]              hh_reg, hh_next, hl_reg, hl_next;

    logic                     ov_reg, ov_next;
    logic                     om_reg, om_next;
    logic [3:0]               os_reg, os_next;
    logic [TEXT_W-1:0]        ot_reg, ot_next;
    logic [4:0]               or_reg, or_next;
    logic                     ok_reg, ok_next;

    logic                     out_free;
    logic                     wr_en;
    logic [SW-1:0]            wr_idx;

    assign out_free      = !ov_reg || out_ready;
    assign out_valid     = ov_reg;
    assign out_matched   = om_reg;
    assign out_slot      = os_reg;
    assign out_text      = ot_reg;
    assign out_remaining = or_reg;
    assign out_skipped   = ok_reg;
    assign wr_idx        = SW'(q_data.slot);

    // message block: letters, pad byte, bit length
    logic [511:0] blk;
    always_comb
    begin
        blk = '0;
        for (int i = 0; i < PASSWORD_LENGTH; i++)
        begin
            blk[i*8 +: 8] = let_reg[i*8 +: 8];
        end
        blk[PASSWORD_LENGTH*8 +: 8] = 8'h80;
        blk[56*8 +: 8]              = 8'(PASSWORD_LENGTH * 8);
    end

    // one MD5 round
    logic [31:0] f, w, sum, rot;
    logic [3:0]  g;
    logic [63:0] dbl;
    always_comb
    begin
        unique case (round_reg[5:4])
            2'd0:
            begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                g = round_reg[3:0];
            end
            2'd1:
            begin
                f = (d_reg & b_reg) | (~d_reg & c_reg);
                g = 4'(8'(round_reg) * 8'd5 + 8'd1);
            end
            2'd2:
            begin
                f = b_reg ^ c_reg ^ d_reg;
                g = 4'(8'(round_reg) * 8'd3 + 8'd5);
            end
            default:
            begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = 4'(8'(round_reg) * 8'd7);
            end
        endcase
        w   = blk[g*32 +: 32];
        sum = a_reg + f + md5_k(round_reg) + w;
        dbl = {sum, sum} << md5_rot({round_reg[5:4], round_reg[1:0]});
        rot = dbl[63:32];
    end

    // password text, first letter in top used byte
    logic [63:0] text_full;
    always_comb
    begin
        text_full = '0;
        for (int i = 0; i < PASSWORD_LENGTH; i++)
        begin
            text_full = (text_full << 8) | 64'(let_reg[i*8 +: 8]);
        end
    end

    // lowest matching valid slot
    logic          hit;
    logic [SW-1:0] hit_idx;
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int k = TARGET_SLOTS - 1; k >= 0; k--)
        begin
            if (valid_reg[k] && tgt_hi[k] == hh_reg && tgt_lo[k] == hl_reg)
            begin
                hit     = 1'b1;
                hit_idx = SW'(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            valid_reg <= '0;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        let_reg   <= let_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        round_reg <= round_next;
        hh_reg    <= hh_next;
        hl_reg    <= hl_next;
        om_reg    <= om_next;
        os_reg    <= os_next;
        ot_reg    <= ot_next;
        or_reg    <= or_next;
        ok_reg    <= ok_next;
    end

    // target storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tgt_hi[wr_idx] <= q_data.dig_hi;
            tgt_lo[wr_idx] <= q_data.dig_lo;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        count_next = count_reg;
        let_next   = let_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        round_next = round_reg;
        hh_next    = hh_reg;
        hl_next    = hl_reg;
        ov_next    = ov_reg && !out_ready;
        om_next    = om_reg;
        os_next    = os_reg;
        ot_next    = ot_reg;
        or_next    = or_reg;
        ok_next    = ok_reg;
        pop        = 1'b0;
        wr_en      = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    pop = 1'b1;
                    if (q_data.cmd == CMD_LOAD)
                    begin
                        if (32'(q_data.slot) < 32'(TARGET_SLOTS))
                        begin
                            wr_en = 1'b1;
                            valid_next[wr_idx] = 1'b1;
                            if (!valid_reg[wr_idx])
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ov_next = 1'b1;
                        om_next = 1'b0;
                        os_next = '0;
                        ot_next = '0;
                        or_next = 5'(count_next);
                        ok_next = 1'b0;
                    end
                    else if (count_reg == '0)
                    begin
                        ov_next = 1'b1;
                        om_next = 1'b0;
                        os_next = '0;
                        ot_next = '0;
                        or_next = '0;
                        ok_next = 1'b1;
                    end
                    else
                    begin
                        let_next   = q_data.letters;
                        a_next     = IV_A;
                        b_next     = IV_B;
                        c_next     = IV_C;
                        d_next     = IV_D;
                        round_next = '0;
                        state_next = B_HASH;
                    end
                end
            end
            B_HASH:
            begin
                a_next     = d_reg;
                d_next     = c_reg;
                c_next     = b_reg;
                b_next     = b_reg + rot;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = B_FIN;
                end
            end
            B_FIN:
            begin
                a_next = IV_A + a_reg;
                b_next = IV_B + b_reg;
                c_next = IV_C + c_reg;
                d_next = IV_D + d_reg;
                hh_next = {a_next[7:0], a_next[15:8], a_next[23:16], a_next[31:24],
                           b_next[7:0], b_next[15:8], b_next[23:16], b_next[31:24]};
                hl_next = {c_next[7:0], c_next[15:8], c_next[23:16], c_next[31:24],
                           d_next[7:0], d_next[15:8], d_next[23:16], d_next[31:24]};
                state_next = B_CMP;
            end
            B_CMP:
            begin
                if (out_free)
                begin
                    if (hit)
                    begin
                        valid_next[hit_idx] = 1'b0;
                        count_next = count_reg - CW'(1);
                    end
                    ov_next    = 1'b1;
                    om_next    = hit;
                    os_next    = hit ? 4'(hit_idx) : 4'd0;
                    ot_next    = text_full[TEXT_W-1:0];
                    or_next    = 5'(count_next);
                    ok_next    = 1'b0;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

endmodule

/* tb/sv/md5_password_search_core_tb.sv */
// ============================================================================
// md5_password_search_core_tb
// Self-checking bench for the MD5 password search core: drives load and
// try beats, predicts each result with its own MD5 and target table, and
// compares every output beat field by field under random stalls.
// ============================================================================
module md5_password_search_core_tb;
    import md5ps_pkg::*;

    localparam int          SLOT_COUNT = 16;
    localparam int          NUM_ITEMS  = 950;
    localparam int          QUIET_FROM = 850;
    localparam int          IDLE_LIMIT = 4000;
    localparam logic [28:0] CAND_SPAN  = 29'd308915776;   // 26^6

    localparam logic [31:0] SINE_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int SHIFT_TAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                      4, 11, 16, 23, 6, 10, 15, 21};

    typedef struct {
        logic        matched;
        logic [3:0]  slot;
        logic [47:0] text;
        logic [4:0]  remaining;
        logic        skipped;
    } search_result_t;

    // candidate index -> six letters, first letter in the top byte
    function automatic logic [47:0] spell_candidate(input logic [28:0] cand);
        logic [47:0] text;
        int          i;
        text = '0;
        for (i = 0; i < 6; i++)
        begin
            text[8*i +: 8] = CHAR_A + 8'(cand % 26);
            cand = cand / 26;
        end
        return text;
    endfunction

    function automatic logic [31:0] byte_swap(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // single-block MD5 of a six-letter message; {bytes 0..7, bytes 8..15}
    function automatic logic [127:0] md5_six(input logic [47:0] text);
        logic [7:0]  blk [64];
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t, x;
        int          i, g, s;
        for (i = 0; i < 64; i++)
            blk[i] = 8'h00;
        for (i = 0; i < 6; i++)
            blk[i] = text[47-8*i -: 8];
        blk[6]  = 8'h80;
        blk[56] = 8'd48;
        for (i = 0; i < 16; i++)
            w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
        a = IV_A; b = IV_B; c = IV_C; d = IV_D;
        for (i = 0; i < 64; i++)
        begin
            if (i < 16)
            begin
                f = (b & c) | (~b & d); g = i;
            end
            else if (i < 32)
            begin
                f = (d & b) | (~d & c); g = (5*i + 1) % 16;
            end
            else if (i < 48)
            begin
                f = b ^ c ^ d; g = (3*i + 5) % 16;
            end
            else
            begin
                f = c ^ (b | ~d); g = (7*i) % 16;
            end
            s = SHIFT_TAB[(i / 16) * 4 + (i % 4)];
            x = a + f + SINE_TAB[i] + w[g];
            t = d; d = c; c = b;
            b = b + ((x << s) | (x >> (32 - s)));
            a = t;
        end
        return {byte_swap(IV_A + a), byte_swap(IV_B + b),
                byte_swap(IV_C + c), byte_swap(IV_D + d)};
    endfunction

    // target table mirror and queue of results still owed by the core
    class search_scoreboard;
        search_result_t owed_q[$];
        bit             armed [SLOT_COUNT];
        logic [127:0]   target [SLOT_COUNT];
        int             errors;

        function int armed_count();
            int n;
            n = 0;
            foreach (armed[k])
                n += armed[k];
            return n;
        endfunction

        function void note_beat(logic cmd, logic [3:0] slot, logic [127:0] dig,
                                logic [28:0] cand);
            search_result_t r;
            logic [127:0]   h;
            int             k;
            r = '{1'b0, 4'd0, 48'd0, 5'd0, 1'b0};
            if (cmd == CMD_LOAD)
            begin
                target[slot] = dig;
                armed[slot]  = 1'b1;
            end
            else if (armed_count() == 0)
                r.skipped = 1'b1;
            else
            begin
                r.text = spell_candidate(cand);
                h = md5_six(r.text);
                for (k = 0; k < SLOT_COUNT; k++)
                begin
                    if (armed[k] && target[k] == h)
                    begin
                        armed[k]  = 1'b0;
                        r.matched = 1'b1;
                        r.slot    = 4'(k);
                        break;
                    end
                end
            end
            r.remaining = 5'(armed_count());
            owed_q.push_back(r);
        endfunction

        function void check_beat(logic [63:0] data, logic [1:0] user);
            search_result_t e;
            if (owed_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: tdata=%h tuser=%b", data, user);
                return;
            end
            e = owed_q.pop_front();
            if (user[0] !== e.matched || user[1] !== e.skipped ||
                data[3:0] !== e.slot || data[51:4] !== e.text ||
                data[56:52] !== e.remaining)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch: exp matched=%b skipped=%b slot=%0d text=%h rem=%0d",
                             e.matched, e.skipped, e.slot, e.text, e.remaining);
                    $display("          got matched=%b skipped=%b slot=%0d text=%h rem=%0d",
                             user[0], user[1], data[3:0], data[51:4], data[56:52]);
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    search_scoreboard sb;
    bit               quiet;
    int               stall_left;
    int               idle_cycles;
    logic [28:0]      planted_q[$];

    md5_password_search_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // drive one beat, optionally after an idle burst, and wait for acceptance
    task automatic send_beat(input logic cmd, input logic [3:0] slot,
                             input logic [127:0] dig, input logic [28:0] cand);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'd0, cand, dig[63:0], dig[127:64], slot};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_beat(cmd, slot, dig, cand);
    endtask

    task automatic load_target(input logic [3:0] slot, input logic [127:0] dig);
        send_beat(CMD_LOAD, slot, dig, 29'($urandom));
    endtask

    task automatic try_candidate(input logic [28:0] cand);
        send_beat(CMD_TRY, 4'($urandom), {$urandom, $urandom, $urandom, $urandom}, cand);
    endtask

    // plant the digest of a random candidate so a later try can hit it
    task automatic plant_target(input logic [3:0] slot);
        logic [28:0] cand;
        cand = 29'($urandom_range(0, CAND_SPAN - 1));
        planted_q.push_back(cand);
        load_target(slot, md5_six(spell_candidate(cand)));
    endtask

    // result side: random backpressure bursts and checking
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_beat(m_axis_tdata, m_axis_tuser);
            if (stall_left > 0)
            begin
                stall_left    <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left    <= $urandom_range(0, 16);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** md5_password_search_core: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int          n, pick;
        logic [28:0] cand;
        sb            = new();
        rst_n         = 1'b0;
        quiet         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_LOAD;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, duplicates, overwrite, wrap
        try_candidate(29'd0);
        try_candidate(29'h1FFFFFFF);
        load_target(4'd0, md5_six(spell_candidate(29'd0)));
        load_target(4'd15, md5_six(spell_candidate(29'd0)));
        load_target(4'd3, 128'd0);
        load_target(4'd5, {128{1'b1}});
        load_target(4'd5, md5_six(spell_candidate(CAND_SPAN - 1)));
        load_target(4'd9, md5_six(spell_candidate(29'd12345)));
        try_candidate(29'd0);
        try_candidate(29'd0);
        try_candidate(29'd0);
        try_candidate(CAND_SPAN - 1);
        try_candidate(CAND_SPAN + 29'd12345);
        try_candidate(29'h1FFFFFFF);
        try_candidate(29'd77);
        load_target(4'd3, {128{1'b1}});
        n = 16;

        // random: planted targets with hits on them, plus noise digests and misses
        while (n < NUM_ITEMS)
        begin
            if (n >= QUIET_FROM)
                quiet = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 25)
                plant_target(4'($urandom));
            else if (pick < 35)
                load_target(4'($urandom), {$urandom, $urandom, $urandom, $urandom});
            else if (pick < 75 && planted_q.size() > 0)
            begin
                cand = planted_q[$urandom_range(0, planted_q.size() - 1)];
                if (cand < 29'h1FFFFFFF - CAND_SPAN && $urandom_range(0, 3) == 0)
                    cand = cand + CAND_SPAN;
                try_candidate(cand);
            end
            else
                try_candidate(29'($urandom));
            n++;
        end
        s_axis_tvalid <= 1'b0;

        while (sb.owed_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("** md5_password_search_core: PASSED **");
        else
            $display("** md5_password_search_core: FAILED **");
        $finish;
    end

endmodule
